// ===== hw/rtl/spcq_pkg.sv =====
package spcq_pkg;

  // Fixed field widths
  localparam int NUM_CLASSES  = 8;
  localparam int CLASS_W      = 3;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int PRIO_W       = 3;
  localparam int FIELD_W      = 16;
  localparam int OCC_W        = 7;
  localparam int BACKLOG_W    = 22;
  localparam int CFG_INDEX_W  = 4;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ENQ     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ_HI  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEQ_CLS = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // Outcome of the strict-priority pick
  typedef struct packed {
    logic               found;
    logic [CLASS_W-1:0] cls;
  } pick_t;

endpackage

// ===== hw/rtl/spcq_ring_mem.sv =====
// Descriptor ring storage: one write port, one read port, registered read data.
module spcq_ring_mem #(
  parameter int AW = 9,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/spcq_prio_pick.sv =====
// Strict-priority pick over the non-empty classes; ties go to the lowest class.
module spcq_prio_pick (
  input  logic [spcq_pkg::NUM_CLASSES-1:0] nonempty,
  input  logic [spcq_pkg::PRIO_W-1:0]      prio [spcq_pkg::NUM_CLASSES],
  output spcq_pkg::pick_t                  pick
);

  always_comb begin
    logic [spcq_pkg::PRIO_W-1:0] best_prio;
    pick      = '0;
    best_prio = '0;
    for (int i = 0; i < spcq_pkg::NUM_CLASSES; i++) begin
      // strictly greater keeps the earlier (lower) class on a tie
      if (nonempty[i] && (!pick.found || prio[i] > best_prio)) begin
        pick.found = 1'b1;
        pick.cls   = spcq_pkg::CLASS_W'(i);
        best_prio  = prio[i];
      end
    end
  end

endmodule

// ===== hw/rtl/strict_priority_class_queues_top.sv =====
// Channel   Handshake                 Payload
// request   start / busy              in_kind, in_class_id, in_handle, in_length
// result    out_valid (strobe)        out_status, out_served_class, out_handle,
//                                     out_length, out_occupancy, out_backlog_bytes
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Each request passes through the busy states S_ACCESS (class pick and ring access)
// and S_UPDATE (ring read data and backlog update), then the registered result strobe
// is shown while idle, and the next request can be taken in the strobe cycle. The ring
// memory's registered read data is why S_UPDATE exists. Reset clears every queue and
// loads priority N into class N; no clearing pass. The receiver cannot stall.
module strict_priority_class_queues_top #(
  parameter int QUEUE_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [spcq_pkg::KIND_W-1:0]          in_kind,
  input  logic [spcq_pkg::CLASS_W-1:0]         in_class_id,
  input  logic [spcq_pkg::FIELD_W-1:0]         in_handle,
  input  logic [spcq_pkg::FIELD_W-1:0]         in_length,
  // result channel
  output logic                                 out_valid,
  output logic [spcq_pkg::STATUS_W-1:0]        out_status,
  output logic [spcq_pkg::CLASS_W-1:0]         out_served_class,
  output logic [spcq_pkg::FIELD_W-1:0]         out_handle,
  output logic [spcq_pkg::FIELD_W-1:0]         out_length,
  output logic [spcq_pkg::OCC_W-1:0]           out_occupancy,
  output logic [spcq_pkg::BACKLOG_W-1:0]       out_backlog_bytes,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spcq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [spcq_pkg::PRIO_W-1:0]          cfg_data
);

  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int HW  = (HANDLE_BITS < spcq_pkg::FIELD_W) ? HANDLE_BITS : spcq_pkg::FIELD_W;
  localparam int AW  = spcq_pkg::CLASS_W + PW;
  localparam int DW  = HW + spcq_pkg::FIELD_W;
  localparam int OXW = CW + spcq_pkg::OCC_W;
  localparam int NC  = spcq_pkg::NUM_CLASSES;
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_UPDATE
  } state_t;

  state_t state_r;

  // latched request
  logic [spcq_pkg::KIND_W-1:0]  kind_r;
  logic [spcq_pkg::CLASS_W-1:0] cls_r;
  logic [HW-1:0]                handle_r;
  logic [spcq_pkg::FIELD_W-1:0] length_r;

  // per-class queue state
  logic [spcq_pkg::PRIO_W-1:0]    prio_r    [NC];
  logic [PW-1:0]                  head_r    [NC];
  logic [PW-1:0]                  tail_r    [NC];
  logic [CW-1:0]                  count_r   [NC];
  logic [spcq_pkg::BACKLOG_W-1:0] backlog_r [NC];

  // carried from access to update cycle
  logic [spcq_pkg::STATUS_W-1:0] status_r;
  logic [spcq_pkg::CLASS_W-1:0]  tcls_r;
  logic                          deq_r;
  logic                          none_r;

  // registered result
  logic                           out_valid_r;
  logic [spcq_pkg::STATUS_W-1:0]  out_status_r;
  logic [spcq_pkg::CLASS_W-1:0]   out_class_r;
  logic [spcq_pkg::FIELD_W-1:0]   out_handle_r;
  logic [spcq_pkg::FIELD_W-1:0]   out_length_r;
  logic [spcq_pkg::OCC_W-1:0]     out_occ_r;
  logic [spcq_pkg::BACKLOG_W-1:0] out_backlog_r;

  logic                   accept;
  logic [NC-1:0]          nonempty;
  spcq_pkg::pick_t        pick;
  logic [spcq_pkg::CLASS_W-1:0] tcls;
  logic [CW-1:0]          cnt;
  logic                   full;
  logic                   empty;
  logic                   do_enq;
  logic                   do_deq;
  logic                   none_found;
  logic [spcq_pkg::STATUS_W-1:0] status_nxt;
  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_raddr;
  logic [DW-1:0]          mem_rdata;
  logic [HW-1:0]          rd_handle;
  logic [spcq_pkg::FIELD_W-1:0]  rd_length;
  logic [spcq_pkg::BACKLOG_W-1:0] backlog_nxt;
  logic [OXW-1:0]         occ_ext;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // priority pick over the occupancy flags
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      nonempty[i] = (count_r[i] != '0);
    end
  end

  spcq_prio_pick u_pick (
    .nonempty (nonempty),
    .prio     (prio_r),
    .pick     (pick)
  );

  // decode of the latched request
  always_comb begin
    tcls       = (kind_r == spcq_pkg::KIND_DEQ_HI) ? pick.cls : cls_r;
    cnt        = count_r[tcls];
    full       = (cnt == CNT_FULL);
    empty      = (cnt == '0);
    none_found = (kind_r == spcq_pkg::KIND_DEQ_HI) && !pick.found;
    do_enq     = (kind_r == spcq_pkg::KIND_ENQ) && !full;
    do_deq     = ((kind_r == spcq_pkg::KIND_DEQ_HI) && pick.found) ||
                 ((kind_r == spcq_pkg::KIND_DEQ_CLS) && !empty);
    case (kind_r)
      spcq_pkg::KIND_ENQ:     status_nxt = full ? spcq_pkg::ST_DROPPED : spcq_pkg::ST_ENQUEUED;
      spcq_pkg::KIND_DEQ_HI:  status_nxt = pick.found ? spcq_pkg::ST_DEQUEUED : spcq_pkg::ST_EMPTY;
      spcq_pkg::KIND_DEQ_CLS: status_nxt = empty ? spcq_pkg::ST_EMPTY : spcq_pkg::ST_DEQUEUED;
      default:                status_nxt = spcq_pkg::ST_EMPTY;
    endcase
  end

  // ring access: enqueue writes at tail, dequeue reads at head
  assign mem_we    = (state_r == S_ACCESS) && do_enq;
  assign mem_re    = (state_r == S_ACCESS) && do_deq;
  assign mem_waddr = {tcls, tail_r[tcls]};
  assign mem_raddr = {tcls, head_r[tcls]};

  spcq_ring_mem #(
    .AW (AW),
    .DW (DW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data ({handle_r, length_r}),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign rd_handle = mem_rdata[DW-1:spcq_pkg::FIELD_W];
  assign rd_length = mem_rdata[spcq_pkg::FIELD_W-1:0];

  // update-cycle result values
  assign backlog_nxt = deq_r ? (backlog_r[tcls_r] - spcq_pkg::BACKLOG_W'(rd_length))
                             : backlog_r[tcls_r];
  assign occ_ext     = OXW'(count_r[tcls_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        prio_r[i]    <= spcq_pkg::PRIO_W'(i);
        head_r[i]    <= '0;
        tail_r[i]    <= '0;
        count_r[i]   <= '0;
        backlog_r[i] <= '0;
      end
    end else begin
      // result strobe follows the update cycle
      out_valid_r <= (state_r == S_UPDATE);

      // priority writes
      if (cfg_valid && cfg_ready && (cfg_index < spcq_pkg::CFG_INDEX_W'(NC))) begin
        prio_r[cfg_index[spcq_pkg::CLASS_W-1:0]] <= cfg_data;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r   <= in_kind;
            cls_r    <= in_class_id;
            handle_r <= in_handle[HW-1:0];
            length_r <= in_length;
            state_r  <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          // pointers and counts move now; dequeue backlog waits for read data
          if (do_enq) begin
            tail_r[tcls]    <= (tail_r[tcls] == PTR_LAST) ? '0 : tail_r[tcls] + 1'b1;
            count_r[tcls]   <= cnt + 1'b1;
            backlog_r[tcls] <= backlog_r[tcls] + spcq_pkg::BACKLOG_W'(length_r);
          end
          if (do_deq) begin
            head_r[tcls]  <= (head_r[tcls] == PTR_LAST) ? '0 : head_r[tcls] + 1'b1;
            count_r[tcls] <= cnt - 1'b1;
          end
          status_r <= status_nxt;
          tcls_r   <= tcls;
          deq_r    <= do_deq;
          none_r   <= none_found;
          state_r  <= S_UPDATE;
        end
        S_UPDATE: begin
          if (deq_r) begin
            backlog_r[tcls_r] <= backlog_nxt;
          end
          out_status_r  <= status_r;
          out_class_r   <= none_r ? '0 : tcls_r;
          out_handle_r  <= deq_r ? spcq_pkg::FIELD_W'(rd_handle) : '0;
          out_length_r  <= deq_r ? rd_length : '0;
          out_occ_r     <= none_r ? '0 : occ_ext[spcq_pkg::OCC_W-1:0];
          out_backlog_r <= none_r ? '0 : backlog_nxt;
          state_r       <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_served_class  = out_class_r;
  assign out_handle        = out_handle_r;
  assign out_length        = out_length_r;
  assign out_occupancy     = out_occ_r;
  assign out_backlog_bytes = out_backlog_r;

endmodule
